FILE: rtl/ntc_pkg.sv
// Shared constants, types and codes for the NTC table interpolator.
`default_nettype none

package ntc_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int ADDR_W      = $clog2(MAX_ENTRIES);
  localparam int N_W         = $clog2(MAX_ENTRIES + 1);
  localparam int COUNT_W     = 7;
  localparam int INDEX_W     = 6;
  localparam int CODE_W      = 16;
  localparam int TEMP_W      = 16;
  localparam int WORD_W      = CODE_W + TEMP_W;
  localparam int RES_W       = 24;
  localparam int FRAC_W      = 8;
  localparam int PROD1_W     = TEMP_W + CODE_W + 1;
  localparam int PROD2_W     = TEMP_W + CODE_W + 2;
  localparam int SUM_W       = PROD2_W + 1;
  localparam int MAG_W       = PROD2_W + FRAC_W;
  localparam int DIV_CNT_W   = $clog2(MAG_W + 1);

  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FIRST,
    ST_LAST,
    ST_SCAN,
    ST_MUL1,
    ST_MUL2,
    ST_SUM,
    ST_DIV,
    ST_WAIT,
    ST_FIX,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic done;
    logic rem_nz;
  } div_status_t;

endpackage

`default_nettype wire

FILE: rtl/ntc_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
`default_nettype none

module ntc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/ntc_divider.sv
// Restoring divider, one quotient bit per cycle, with remainder-nonzero flag.
`default_nettype none

module ntc_divider (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [ntc_pkg::MAG_W-1:0]  dividend,
  input  logic [ntc_pkg::CODE_W-1:0] divisor,
  output logic [ntc_pkg::MAG_W-1:0]  quotient,
  output ntc_pkg::div_status_t       status
);
  import ntc_pkg::*;

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [MAG_W-1:0]     dvd;
  logic [CODE_W-1:0]    rem;
  logic [CODE_W:0]      rem_sh;
  logic [CODE_W:0]      rem_sub;
  logic                 fits;

  assign rem_sh  = {rem, dvd[MAG_W-1]};
  assign fits    = rem_sh >= {1'b0, divisor};
  assign rem_sub = rem_sh - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(MAG_W);
        dvd  <= dividend;
        rem  <= '0;
      end else if (busy) begin
        dvd <= {dvd[MAG_W-2:0], fits};
        rem <= fits ? rem_sub[CODE_W-1:0] : rem_sh[CODE_W-1:0];
        cnt <= cnt - DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient      = dvd;
  assign status.done   = done;
  assign status.rem_nz = rem != '0;

endmodule

`default_nettype wire

FILE: rtl/ntc_table_interpolator.sv
// Top level: table store, lookup sequencer, interpolation datapath, result register.
//
// A write item stores one (code, temperature) entry. A lookup reads the table
// through one RAM read port, one entry per cycle: the first and last entries for
// the clamp test, then a forward scan for the segment. A clamped lookup or an
// empty table skips the scan and the divider; an interpolated lookup runs the
// scan (one read per entry, over at most n entries, n being table_count capped
// at 64) and the 42-step serial divider. The result sits in an output register,
// so the next item is taken while it waits. The table holds no valid bits:
// entries below table_count must be written before a lookup uses them.
`default_nettype none

module ntc_table_interpolator (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wr_en,
  input  logic [ntc_pkg::COUNT_W-1:0]        cfg_wr_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               func,
  input  logic [ntc_pkg::INDEX_W-1:0]        entry_index,
  input  logic [ntc_pkg::CODE_W-1:0]         entry_code,
  input  logic signed [ntc_pkg::TEMP_W-1:0]  entry_temp,
  input  logic [ntc_pkg::CODE_W-1:0]         adc_code,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [ntc_pkg::RES_W-1:0]   temperature,
  output logic                               table_empty
);
  import ntc_pkg::*;

  state_t state, state_next;

  logic [COUNT_W-1:0]        table_count;
  logic [N_W-1:0]            n_eff;
  logic [N_W-1:0]            n;
  logic [ADDR_W-1:0]         idx;
  logic [CODE_W-1:0]         code;
  logic [CODE_W-1:0]         prev_code;
  logic signed [TEMP_W-1:0]  prev_temp;
  logic signed [TEMP_W-1:0]  next_temp;
  logic [CODE_W-1:0]         den;
  logic signed [PROD1_W-1:0] p1;
  logic signed [PROD2_W-1:0] p2;
  logic signed [SUM_W-1:0]   sum;
  logic signed [TEMP_W:0]    tdiff;
  logic [MAG_W-1:0]          num;
  logic [MAG_W-1:0]          mag;
  logic [MAG_W-1:0]          quo;
  logic [MAG_W:0]            qs;
  logic [RES_W-1:0]          res_sat;
  logic signed [RES_W-1:0]   res;
  logic                      res_empty;
  div_status_t               div_stat;
  logic                      div_start;

  logic                      ram_we;
  logic [ADDR_W-1:0]         ram_raddr;
  logic [WORD_W-1:0]         ram_rdata;
  logic [CODE_W-1:0]         rd_code;
  logic signed [TEMP_W-1:0]  rd_temp;
  logic                      scan_hit;
  logic                      scan_end;
  logic                      out_free;

  assign rd_code = ram_rdata[WORD_W-1:TEMP_W];
  assign rd_temp = ram_rdata[TEMP_W-1:0];

  assign n_eff = (32'(table_count) > MAX_ENTRIES) ? N_W'(MAX_ENTRIES) : N_W'(table_count);

  assign ram_we = (state == ST_IDLE) && in_valid && (func == FUNC_WRITE)
                  && (32'(entry_index) < MAX_ENTRIES);

  ntc_ram #(
    .WIDTH(WORD_W),
    .DEPTH(MAX_ENTRIES)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ADDR_W'(entry_index)),
    .wdata({entry_code, entry_temp}),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign mag = num[MAG_W-1] ? (~num + MAG_W'(1)) : num;

  ntc_divider u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(mag),
    .divisor (den),
    .quotient(quo),
    .status  (div_stat)
  );

  assign scan_hit = (code <= rd_code) && (rd_code > prev_code);
  assign scan_end = ((N_W+1)'(idx) + (N_W+1)'(2)) >= (N_W+1)'(n);
  assign out_free = !out_valid || out_ready;

  assign tdiff = $signed({next_temp[TEMP_W-1], next_temp})
               - $signed({prev_temp[TEMP_W-1], prev_temp});
  assign sum   = $signed({{(SUM_W-PROD1_W){p1[PROD1_W-1]}}, p1})
               + $signed({{(SUM_W-PROD2_W){p2[PROD2_W-1]}}, p2});

  // floor for negative values: -(q + (rem != 0))
  always_comb begin
    if (num[MAG_W-1]) begin
      qs = div_stat.rem_nz ? ~{1'b0, quo} : (~{1'b0, quo} + (MAG_W+1)'(1));
    end else begin
      qs = {1'b0, quo};
    end
    if (qs[MAG_W:RES_W-1] == {(MAG_W-RES_W+2){qs[MAG_W]}}) begin
      res_sat = qs[RES_W-1:0];
    end else if (qs[MAG_W]) begin
      res_sat = {1'b1, {(RES_W-1){1'b0}}};
    end else begin
      res_sat = {1'b0, {(RES_W-1){1'b1}}};
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    ram_raddr  = '0;
    div_start  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && (func == FUNC_LOOKUP)) begin
          state_next = (n_eff == '0) ? ST_DONE : ST_FIRST;
        end
      end
      ST_FIRST: begin
        ram_raddr  = ADDR_W'(n - N_W'(1));
        state_next = (code <= rd_code) ? ST_DONE : ST_LAST;
      end
      ST_LAST: begin
        ram_raddr  = idx + ADDR_W'(1);
        state_next = (code >= rd_code) ? ST_DONE : ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_hit) begin
          state_next = ST_MUL1;
        end else if (scan_end) begin
          state_next = ST_DONE;
        end else begin
          ram_raddr = idx + ADDR_W'(2);
        end
      end
      ST_MUL1: state_next = ST_MUL2;
      ST_MUL2: state_next = ST_SUM;
      ST_SUM:  state_next = ST_DIV;
      ST_DIV: begin
        div_start  = 1'b1;
        state_next = ST_WAIT;
      end
      ST_WAIT: begin
        if (div_stat.done) begin
          state_next = ST_FIX;
        end
      end
      ST_FIX: state_next = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      table_count <= '0;
    end else if (cfg_wr_en) begin
      table_count <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_valid && (func == FUNC_LOOKUP)) begin
          code      <= adc_code;
          n         <= n_eff;
          idx       <= '0;
          res       <= '0;
          res_empty <= (n_eff == '0);
        end
      end
      ST_FIRST: begin
        prev_code <= rd_code;
        prev_temp <= rd_temp;
        res       <= {rd_temp, {FRAC_W{1'b0}}};
      end
      ST_LAST: begin
        res <= {rd_temp, {FRAC_W{1'b0}}};
      end
      ST_SCAN: begin
        if (scan_hit) begin
          next_temp <= rd_temp;
          den       <= rd_code - prev_code;
        end else begin
          prev_code <= rd_code;
          prev_temp <= rd_temp;
          idx       <= idx + ADDR_W'(1);
        end
      end
      ST_MUL1: p1 <= prev_temp * $signed({1'b0, den});
      ST_MUL2: p2 <= $signed({1'b0, code - prev_code}) * tdiff;
      ST_SUM:  num <= {sum[PROD2_W-1:0], {FRAC_W{1'b0}}};
      ST_FIX:  res <= res_sat;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_DONE) && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_DONE) && out_free) begin
      temperature <= res;
      table_empty <= res_empty;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/ntc_checker.sv
// Port-level checks for the NTC table interpolator, bound to the top level.
`default_nettype none

module ntc_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              func,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [ntc_pkg::RES_W-1:0]  temperature,
  input logic                              table_empty
);
  import ntc_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(temperature) && $stable(table_empty))
    else $error("result changed while stalled");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && table_empty |-> temperature == '0)
    else $error("empty table result is not zero");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result present after reset");

  a_lookup_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (func == FUNC_LOOKUP) |=> !in_ready)
    else $error("transfer taken during a lookup");

  a_write_silent: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (func == FUNC_WRITE) && !out_valid |=> !out_valid)
    else $error("write item produced a result");

endmodule

bind ntc_table_interpolator ntc_checker u_ntc_checker (.*);

`default_nettype wire
